/* src/cbs_pkg.sv */
package cbs_pkg;

  // Default configuration
  localparam int SEGMENTS_PER_SPAN_DEF = 20;
  localparam int COORD_BITS_DEF        = 11;

  // Spans buffered between the point front end and the segment back end
  localparam int QUEUE_DEPTH = 2;

  // Register stages through the sample unit
  localparam int SAMPLE_LAT = 6;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

  // Integer uniform cubic B-spline basis weight j at sample k of n.
  // The four weights sum to 6*n^3.
  function automatic int bspline_weight(input int j, input int k, input int n);
    int r;
    int res;
    r = n - k;
    case (j)
      0:       res = r * r * r;
      1:       res = 3 * k * k * k - 6 * n * k * k + 4 * n * n * n;
      2:       res = -3 * k * k * k + 3 * n * k * k + 3 * n * n * k + n * n * n;
      default: res = k * k * k;
    endcase
    return res;
  endfunction

endpackage

/* src/cubic_bspline_segment_eval.sv */
// Uniform cubic B-spline span evaluator. Control points stream in on the in_
// channel; every point from the fourth on (since reset or the last restart)
// closes a span, and the block returns SEGMENTS_PER_SPAN line segments for it
// on the out_ channel, each joining two curve samples truncated toward zero,
// with out_last_segment marking the final one. The first three points of a
// curve are taken one per cycle while the span queue has room. After that,
// each point needs the span's SEGMENTS_PER_SPAN+1 samples from the x and y
// sample pipelines, which produce one curve sample per cycle while no finished
// segment is held by the sink; a two-span queue lets the input run ahead of
// that. No clearing pass is needed after reset.
module cubic_bspline_segment_eval #(
  parameter int SEGMENTS_PER_SPAN = cbs_pkg::SEGMENTS_PER_SPAN_DEF,
  parameter int COORD_BITS        = cbs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_seg_x0,
  output logic signed [COORD_BITS-1:0] out_seg_y0,
  output logic signed [COORD_BITS-1:0] out_seg_x1,
  output logic signed [COORD_BITS-1:0] out_seg_y1,
  output logic                         out_last_segment
);

  localparam int SPW = 8 * COORD_BITS;

  cbs_pkg::qstat_t q_stat;
  logic            q_push;
  logic            q_pop;
  logic [SPW-1:0]  q_wdata;
  logic [SPW-1:0]  q_rdata;

  // Point window and span classification
  cbs_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_px      (in_px),
    .in_py      (in_py),
    .in_restart (in_restart),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // Span queue
  cbs_queue #(
    .WIDTH (SPW),
    .DEPTH (cbs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Segment generation
  cbs_back #(
    .SEGMENTS_PER_SPAN (SEGMENTS_PER_SPAN),
    .COORD_BITS        (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_last_segment (out_last_segment)
  );

endmodule

/* src/cbs_front.sv */
module cbs_front #(
  parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic                        in_restart,
  input  cbs_pkg::qstat_t             q_stat,
  output logic                        q_push,
  output logic [8*COORD_BITS-1:0]     q_wdata
);

  logic [COORD_BITS-1:0] held_x_r [3];
  logic [COORD_BITS-1:0] held_y_r [3];
  logic [COORD_BITS-1:0] held_x_nxt [3];
  logic [COORD_BITS-1:0] held_y_nxt [3];
  logic [1:0]            cnt_r, cnt_nxt;
  logic [1:0]            eff_cnt;
  logic                  closes;
  logic                  accept;

  // A restart drops the window before this point is taken
  assign eff_cnt  = in_restart ? 2'd0 : cnt_r;
  assign closes   = (eff_cnt == 2'd3);
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && closes;

  // Span = three held points (oldest first) and the new point
  assign q_wdata = {in_py, in_px, held_y_r[2], held_x_r[2],
                    held_y_r[1], held_x_r[1], held_y_r[0], held_x_r[0]};

  // Window update
  always_comb begin
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      if (closes) begin
        held_x_nxt[0] = held_x_r[1];
        held_y_nxt[0] = held_y_r[1];
        held_x_nxt[1] = held_x_r[2];
        held_y_nxt[1] = held_y_r[2];
        held_x_nxt[2] = in_px;
        held_y_nxt[2] = in_py;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (in_restart) begin
            held_x_nxt[i] = '0;
            held_y_nxt[i] = '0;
          end
          if (eff_cnt == 2'(i)) begin
            held_x_nxt[i] = in_px;
            held_y_nxt[i] = in_py;
          end
        end
        cnt_nxt = eff_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        held_x_r[i] <= '0;
        held_y_r[i] <= '0;
      end
    end else begin
      cnt_r    <= cnt_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
    end
  end

endmodule

/* src/cbs_queue.sv */
module cbs_queue #(
  parameter int WIDTH = 8 * cbs_pkg::COORD_BITS_DEF,
  parameter int DEPTH = cbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output cbs_pkg::qstat_t  stat
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign rdata         = mem_r[rd_ptr_r];
  assign stat.full     = (cnt_r == CNTW'(DEPTH));
  assign stat.nonempty = (cnt_r != '0);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* src/cbs_sample.sv */
module cbs_sample #(
  parameter int SEGMENTS_PER_SPAN = cbs_pkg::SEGMENTS_PER_SPAN_DEF,
  parameter int COORD_BITS        = cbs_pkg::COORD_BITS_DEF,
  localparam int WW = $clog2(4 * SEGMENTS_PER_SPAN * SEGMENTS_PER_SPAN * SEGMENTS_PER_SPAN + 1)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [3:0][WW-1:0]           w,
  input  logic [3:0][COORD_BITS-1:0]   p,
  output logic signed [COORD_BITS-1:0] res
);

  localparam int     CB  = COORD_BITS;
  localparam longint DIV = longint'(6) * SEGMENTS_PER_SPAN * SEGMENTS_PER_SPAN
                           * SEGMENTS_PER_SPAN;
  localparam int     DW  = $clog2(DIV + 1);      // bits of the divisor
  localparam int     R   = DW - 1;               // 2^R <= DIV
  localparam int     AW  = $clog2(DIV) + CB + 1; // weighted sum
  localparam int     PW  = WW + CB + 1;          // one product
  localparam int     MW  = AW - 1;               // magnitude
  localparam int     TW  = MW - R;               // magnitude top bits
  localparam int     S   = CB + 1;
  localparam int     QW  = CB + 1;               // quotient
  localparam int     MBW = CB + 2;
  localparam longint M   = (longint'(1) << (R + S)) / DIV;
  localparam int     LW  = R + 3;                // remainder bits, r < 3*DIV

  logic signed [PW-1:0] prod [4];
  logic signed [PW-1:0] prod_r [4];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_r;
  logic                 neg3_r, neg4_r, neg5_r;
  logic [MW-1:0]        mag_r;
  logic [TW+MBW-1:0]    tmul;
  logic [QW-1:0]        e4_r, e5_r;
  logic [LW-1:0]        maglo4_r, maglo5_r;
  logic [QW+DW-1:0]     pe;
  logic [LW-1:0]        pelo_r;
  logic [LW-1:0]        rem;
  logic [QW-1:0]        q;
  logic signed [CB-1:0] res_r;

  // Stage 1: weight times coordinate
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod[j] = $signed({1'b0, w[j]}) * $signed(p[j]);
    end
  end

  // Stage 2: weighted sum
  assign acc = AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2]) + AW'(prod_r[3]);

  // Stage 4: quotient estimate from the top magnitude bits, low by at most two
  assign tmul = TW'(mag_r[MW-1:R]) * MBW'(M);

  // Stage 5: back-multiply the estimate, only the low bits matter
  assign pe = e4_r * DW'(DIV);

  // Stage 6: correct the estimate, restore the sign (truncation toward zero)
  assign rem = maglo5_r - pelo_r;
  assign q   = e5_r + QW'(rem >= LW'(DIV)) + QW'(rem >= LW'(2 * DIV));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod;
      acc_r    <= acc;
      neg3_r   <= acc_r[AW-1];
      mag_r    <= MW'(acc_r[AW-1] ? -acc_r : acc_r);
      e4_r     <= QW'(tmul >> S);
      maglo4_r <= mag_r[LW-1:0];
      neg4_r   <= neg3_r;
      pelo_r   <= pe[LW-1:0];
      e5_r     <= e4_r;
      maglo5_r <= maglo4_r;
      neg5_r   <= neg4_r;
      res_r    <= CB'(neg5_r ? -q : q);
    end
  end

  assign res = res_r;

endmodule

/* src/cbs_back.sv */
module cbs_back #(
  parameter int SEGMENTS_PER_SPAN = cbs_pkg::SEGMENTS_PER_SPAN_DEF,
  parameter int COORD_BITS        = cbs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cbs_pkg::qstat_t              q_stat,
  input  logic [8*COORD_BITS-1:0]      q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_seg_x0,
  output logic signed [COORD_BITS-1:0] out_seg_y0,
  output logic signed [COORD_BITS-1:0] out_seg_x1,
  output logic signed [COORD_BITS-1:0] out_seg_y1,
  output logic                         out_last_segment
);

  localparam int N   = SEGMENTS_PER_SPAN;
  localparam int CB  = COORD_BITS;
  localparam int KW  = $clog2(N + 1);
  localparam int WW  = $clog2(4 * N * N * N + 1);
  localparam int LAT = cbs_pkg::SAMPLE_LAT;

  logic [WW-1:0]        wtab [N+1][4];
  logic [3:0][WW-1:0]   w;
  logic [3:0][CB-1:0]   px, py;
  logic [8*CB-1:0]      span_r, span_nxt;
  logic                 busy_r, busy_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 k_end;
  logic                 adv;
  logic [LAT-1:0]       tag_v_r, tag_first_r, tag_last_r;
  logic signed [CB-1:0] sx, sy;
  logic signed [CB-1:0] prev_x_r, prev_y_r;
  logic                 emit;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [CB-1:0] x0_r, y0_r, x1_r, y1_r;
  logic                 last_r;

  // Basis weight table, one row per sample index 0..N
  for (genvar kk = 0; kk <= N; kk++) begin : g_wrow
    for (genvar j = 0; j < 4; j++) begin : g_wcol
      assign wtab[kk][j] = WW'(cbs_pkg::bspline_weight(j, kk, N));
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      w[j]  = wtab[k_r][j];
      px[j] = span_r[2*j*CB +: CB];
      py[j] = span_r[(2*j+1)*CB +: CB];
    end
  end

  // Sample issue and pipeline advance unless a finished segment is held by the sink
  assign adv   = !(out_valid_r && out_stall);
  assign k_end = (k_r == KW'(N));

  // Sample issue: N+1 samples per span, next span loaded on the last one if queued, else idle
  always_comb begin
    span_nxt = span_r;
    busy_nxt = busy_r;
    k_nxt    = k_r;
    q_pop    = 1'b0;
    if (!busy_r) begin
      if (q_stat.nonempty) begin
        q_pop    = 1'b1;
        span_nxt = q_rdata;
        busy_nxt = 1'b1;
        k_nxt    = '0;
      end
    end else if (adv) begin
      k_nxt = k_r + KW'(1);
      if (k_end) begin
        k_nxt = '0;
        if (q_stat.nonempty) begin
          q_pop    = 1'b1;
          span_nxt = q_rdata;
        end else begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  // Sample units for x and y
  cbs_sample #(
    .SEGMENTS_PER_SPAN (N),
    .COORD_BITS        (CB)
  ) u_sample_x (
    .clk (clk),
    .en  (adv),
    .w   (w),
    .p   (px),
    .res (sx)
  );

  cbs_sample #(
    .SEGMENTS_PER_SPAN (N),
    .COORD_BITS        (CB)
  ) u_sample_y (
    .clk (clk),
    .en  (adv),
    .w   (w),
    .p   (py),
    .res (sy)
  );

  // Tags riding alongside the sample pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_v_r <= '0;
    end else if (adv) begin
      tag_v_r <= {tag_v_r[LAT-2:0], busy_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_first_r <= {tag_first_r[LAT-2:0], (k_r == '0)};
      tag_last_r  <= {tag_last_r[LAT-2:0], k_end};
    end
  end

  // A sample closes a segment unless it is the first of its span
  assign emit          = tag_v_r[LAT-1] && !tag_first_r[LAT-1];
  assign out_valid_nxt = adv ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Segment output register and previous sample
  always_ff @(posedge clk) begin
    if (adv && tag_v_r[LAT-1]) begin
      prev_x_r <= sx;
      prev_y_r <= sy;
      if (!tag_first_r[LAT-1]) begin
        x0_r   <= prev_x_r;
        y0_r   <= prev_y_r;
        x1_r   <= sx;
        y1_r   <= sy;
        last_r <= tag_last_r[LAT-1];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seg_x0       = x0_r;
  assign out_seg_y0       = y0_r;
  assign out_seg_x1       = x1_r;
  assign out_seg_y1       = y1_r;
  assign out_last_segment = last_r;

endmodule

/* src/cbs_checker.sv */
module cbs_checker #(
  parameter int SEGMENTS_PER_SPAN = cbs_pkg::SEGMENTS_PER_SPAN_DEF,
  parameter int COORD_BITS        = cbs_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_seg_x0,
  input logic [COORD_BITS-1:0] out_seg_y0,
  input logic [COORD_BITS-1:0] out_seg_x1,
  input logic [COORD_BITS-1:0] out_seg_y1,
  input logic                  out_last_segment
);

  localparam int CW = $clog2(SEGMENTS_PER_SPAN + 1);

  logic                  out_xfer;
  logic                  prev_ok_r;
  logic [COORD_BITS-1:0] prev_x1_r, prev_y1_r;
  logic [CW-1:0]         seg_cnt_r;

  assign out_xfer = out_valid && !out_stall;

  // Track the previous segment and the position within the span
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ok_r <= 1'b0;
      seg_cnt_r <= '0;
    end else if (out_xfer) begin
      prev_ok_r <= !out_last_segment;
      seg_cnt_r <= out_last_segment ? '0 : seg_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_x1_r <= out_seg_x1;
      prev_y1_r <= out_seg_y1;
    end
  end

  // A held segment stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seg_x0) && $stable(out_seg_y0)
      && $stable(out_seg_x1) && $stable(out_seg_y1) && $stable(out_last_segment))
    else $error("segment changed while stalled");

  // Segments within a span join end to start
  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && prev_ok_r |-> out_seg_x0 == prev_x1_r && out_seg_y0 == prev_y1_r)
    else $error("segment does not start where the previous one ended");

  // The span's last flag comes on exactly the final segment
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (out_last_segment == (seg_cnt_r == CW'(SEGMENTS_PER_SPAN - 1))))
    else $error("last segment flag out of place");

endmodule

bind cubic_bspline_segment_eval cbs_checker #(
  .SEGMENTS_PER_SPAN (SEGMENTS_PER_SPAN),
  .COORD_BITS        (COORD_BITS)
) u_cbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_seg_x0       (out_seg_x0),
  .out_seg_y0       (out_seg_y0),
  .out_seg_x1       (out_seg_x1),
  .out_seg_y1       (out_seg_y1),
  .out_last_segment (out_last_segment)
);
